/* hw/rtl/hrdt_pkg.sv */
// ----------------------------------------------------------------------------
// hrdt_pkg
// Shared types, constants and helpers of the hover region dwell tracker.
// ----------------------------------------------------------------------------
package hrdt_pkg;

	localparam int MAX_REGIONS = 16;
	localparam int IDX_W       = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
	localparam int PADDR_W     = 3;
	localparam int PDATA_W     = 32;
	localparam int DELAY_W     = 16;
	localparam logic [DELAY_W-1:0] DELAY_RESET = 16'd500;

	localparam logic [1:0] CMD_REG   = 2'd0;
	localparam logic [1:0] CMD_CLEAR = 2'd1;
	localparam logic [1:0] CMD_TICK  = 2'd2;

	localparam logic ADDR_DELAY = 1'b0;

	typedef struct packed {
		logic [1:0]         cmd;
		logic [15:0]        window_id;
		logic signed [15:0] rect_x;
		logic signed [15:0] rect_y;
		logic [14:0]        rect_w;
		logic [14:0]        rect_h;
		logic signed [15:0] pointer_x;
		logic signed [15:0] pointer_y;
		logic [31:0]        time_ms;
	} req_t;

	typedef struct packed {
		logic        reg_ok;
		logic [3:0]  reg_slot;
		logic        hover_valid;
		logic [3:0]  hover_slot;
		logic        show_valid;
		logic [3:0]  show_slot;
		logic [15:0] show_window;
	} rsp_t;

	// result handed from cell to cell during a scan
	typedef struct packed {
		logic             valid;
		logic             match_ok;
		logic [IDX_W-1:0] match_idx;
		logic             free_ok;
		logic [IDX_W-1:0] free_idx;
		logic             hit_ok;
		logic [IDX_W-1:0] hit_idx;
		logic [15:0]      hit_window;
	} scan_t;

	// broadcast update to the cells
	typedef struct packed {
		logic             wr;
		logic             clr;
		logic [IDX_W-1:0] wr_slot;
	} ctl_t;

	function automatic logic [3:0] to_slot4(input logic [IDX_W-1:0] idx);
		logic [IDX_W+3:0] t;
		t = {4'b0, idx};
		return t[3:0];
	endfunction

endpackage

/* hw/rtl/hrdt_cell.sv */
// ----------------------------------------------------------------------------
// hrdt_cell
// One table entry. Compares its region against the request and passes the
// running lowest-slot results on to the next cell.
// ----------------------------------------------------------------------------
module hrdt_cell (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [hrdt_pkg::IDX_W-1:0] slot,
	input  hrdt_pkg::ctl_t             ctl,
	input  hrdt_pkg::req_t             req,
	input  hrdt_pkg::scan_t            s_in,
	output hrdt_pkg::scan_t            s_out
);

	logic               used_q;
	logic [15:0]        window_q;
	logic signed [15:0] left_q;
	logic signed [15:0] top_q;
	logic [14:0]        width_q;
	logic [14:0]        height_q;

	logic signed [16:0] px, py, lx, ty, rx, by;
	logic               same, inside_pt;
	hrdt_pkg::scan_t    s_d;

	always_comb begin
		px = 17'(req.pointer_x);
		py = 17'(req.pointer_y);
		lx = 17'(left_q);
		ty = 17'(top_q);
		rx = lx + $signed({2'b0, width_q});
		by = ty + $signed({2'b0, height_q});
		inside_pt = (px >= lx) && (px < rx) && (py >= ty) && (py < by);
		same = (window_q == req.window_id) && (left_q == req.rect_x) &&
			(top_q == req.rect_y) && (width_q == req.rect_w) &&
			(height_q == req.rect_h);

		s_d = s_in;
		if (used_q && same && !s_in.match_ok) begin
			s_d.match_ok  = 1'b1;
			s_d.match_idx = slot;
		end
		if (!used_q && !s_in.free_ok) begin
			s_d.free_ok  = 1'b1;
			s_d.free_idx = slot;
		end
		if (used_q && inside_pt && !s_in.hit_ok) begin
			s_d.hit_ok     = 1'b1;
			s_d.hit_idx    = slot;
			s_d.hit_window = window_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= 1'b0;
			s_out  <= '0;
		end else begin
			s_out <= s_d;
			if (ctl.clr) begin
				used_q <= 1'b0;
			end else if (ctl.wr && ctl.wr_slot == slot) begin
				used_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.wr && ctl.wr_slot == slot) begin
			window_q <= req.window_id;
			left_q   <= req.rect_x;
			top_q    <= req.rect_y;
			width_q  <= req.rect_w;
			height_q <= req.rect_h;
		end
	end

endmodule

/* hw/rtl/hover_region_dwell_tracker_core.sv */
// ----------------------------------------------------------------------------
// hover_region_dwell_tracker_core
// Region table with pointer hover and dwell tracking.
// ----------------------------------------------------------------------------
// A request (register, clear or tick) is taken when start is high and busy is
// low. It travels down a chain of MAX_REGIONS entry cells, one cell per cycle,
// and its single result appears on rsp, marked by done, which is high for one
// cycle; rsp holds it until the next result. busy is high from acceptance until
// the result cycle, so no new request is taken while one is in the chain.
// Results cannot be stalled. dwell_delay_ms sits at byte address 0 of the APB
// port.
module hover_region_dwell_tracker_core (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  hrdt_pkg::req_t               req,
	output logic                         done,
	output hrdt_pkg::rsp_t               rsp,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [hrdt_pkg::PADDR_W-1:0] paddr,
	input  logic [hrdt_pkg::PDATA_W-1:0] pwdata,
	output logic [hrdt_pkg::PDATA_W-1:0] prdata,
	output logic                         pready
);

	localparam int N = hrdt_pkg::MAX_REGIONS;

	logic                         busy_q, launch_q, done_q;
	hrdt_pkg::req_t               req_q;
	logic [hrdt_pkg::DELAY_W-1:0] delay_q;

	logic                         reg_ok_q;
	logic [hrdt_pkg::IDX_W-1:0]   reg_idx_q;
	logic                         hover_ok_q, shown_ok_q;
	logic [hrdt_pkg::IDX_W-1:0]   hover_idx_q, shown_idx_q;
	logic [31:0]                  hover_start_q;
	logic [15:0]                  show_win_q;

	hrdt_pkg::scan_t              chain [N+1];
	hrdt_pkg::scan_t              tail;
	hrdt_pkg::ctl_t               ctl;
	logic [N-1:0]                 chain_valid;

	logic                         reg_ok_d, hover_ok_d, shown_ok_d;
	logic [hrdt_pkg::IDX_W-1:0]   reg_idx_d, hover_idx_d, shown_idx_d;
	logic [31:0]                  hover_start_d, elapsed;
	logic [15:0]                  show_win_d;
	logic                         accept, cfg_wr;

	assign accept = start && !busy_q;
	assign busy   = busy_q;
	assign done   = done_q;
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && paddr[2] == hrdt_pkg::ADDR_DELAY;
	assign prdata = (paddr[2] == hrdt_pkg::ADDR_DELAY) ?
		{{(hrdt_pkg::PDATA_W-hrdt_pkg::DELAY_W){1'b0}}, delay_q} : '0;

	always_comb begin
		chain[0]       = '0;
		chain[0].valid = launch_q;
	end

	for (genvar i = 0; i < N; i++) begin : g_cell
		hrdt_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.slot   (hrdt_pkg::IDX_W'(i)),
			.ctl    (ctl),
			.req    (req_q),
			.s_in   (chain[i]),
			.s_out  (chain[i+1])
		);
		assign chain_valid[i] = chain[i+1].valid;
	end

	assign tail    = chain[N];
	assign elapsed = req_q.time_ms - hover_start_q;

	always_comb begin
		ctl           = '0;
		reg_ok_d      = 1'b0;
		reg_idx_d     = '0;
		hover_ok_d    = hover_ok_q;
		hover_idx_d   = hover_idx_q;
		hover_start_d = hover_start_q;
		shown_ok_d    = shown_ok_q;
		shown_idx_d   = shown_idx_q;
		show_win_d    = show_win_q;
		case (req_q.cmd)
			hrdt_pkg::CMD_REG: begin
				if (tail.match_ok) begin
					reg_ok_d  = 1'b1;
					reg_idx_d = tail.match_idx;
				end else if (tail.free_ok) begin
					reg_ok_d    = 1'b1;
					reg_idx_d   = tail.free_idx;
					ctl.wr      = tail.valid;
					ctl.wr_slot = tail.free_idx;
				end
			end
			hrdt_pkg::CMD_CLEAR: begin
				ctl.clr       = tail.valid;
				hover_ok_d    = 1'b0;
				hover_idx_d   = '0;
				hover_start_d = '0;
				shown_ok_d    = 1'b0;
				shown_idx_d   = '0;
			end
			hrdt_pkg::CMD_TICK: begin
				if (tail.hit_ok != hover_ok_q ||
					(tail.hit_ok && tail.hit_idx != hover_idx_q)) begin
					hover_ok_d    = tail.hit_ok;
					hover_idx_d   = tail.hit_ok ? tail.hit_idx : '0;
					hover_start_d = req_q.time_ms;
					shown_ok_d    = 1'b0;
					shown_idx_d   = '0;
				end else if (tail.hit_ok) begin
					if (!shown_ok_q && elapsed >= {16'b0, delay_q}) begin
						shown_ok_d  = 1'b1;
						shown_idx_d = tail.hit_idx;
						show_win_d  = tail.hit_window;
					end
				end else begin
					shown_ok_d  = 1'b0;
					shown_idx_d = '0;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q        <= 1'b0;
			launch_q      <= 1'b0;
			done_q        <= 1'b0;
			delay_q       <= hrdt_pkg::DELAY_RESET;
			reg_ok_q      <= 1'b0;
			reg_idx_q     <= '0;
			hover_ok_q    <= 1'b0;
			hover_idx_q   <= '0;
			hover_start_q <= '0;
			shown_ok_q    <= 1'b0;
			shown_idx_q   <= '0;
			show_win_q    <= '0;
		end else begin
			launch_q <= accept;
			done_q   <= tail.valid;
			if (cfg_wr) begin
				delay_q <= pwdata[hrdt_pkg::DELAY_W-1:0];
			end
			if (accept) begin
				busy_q <= 1'b1;
			end else if (tail.valid) begin
				busy_q <= 1'b0;
			end
			if (tail.valid) begin
				reg_ok_q      <= reg_ok_d;
				reg_idx_q     <= reg_idx_d;
				hover_ok_q    <= hover_ok_d;
				hover_idx_q   <= hover_idx_d;
				hover_start_q <= hover_start_d;
				shown_ok_q    <= shown_ok_d;
				shown_idx_q   <= shown_idx_d;
				show_win_q    <= show_win_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= req;
		end
	end

	always_comb begin
		rsp.reg_ok      = reg_ok_q;
		rsp.reg_slot    = reg_ok_q ? hrdt_pkg::to_slot4(reg_idx_q) : 4'd0;
		rsp.hover_valid = hover_ok_q;
		rsp.hover_slot  = hover_ok_q ? hrdt_pkg::to_slot4(hover_idx_q) : 4'd0;
		rsp.show_valid  = shown_ok_q;
		rsp.show_slot   = shown_ok_q ? hrdt_pkg::to_slot4(shown_idx_q) : 4'd0;
		rsp.show_window = shown_ok_q ? show_win_q : 16'd0;
	end

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q)
		else $error("result strobe while still busy");

	a_tail_busy: assert property (@(posedge clk) disable iff (!arst_n)
		tail.valid |-> busy_q)
		else $error("scan finished with no request in flight");

	a_one_in_chain: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({launch_q, chain_valid}))
		else $error("more than one request in the cell chain");

	a_show_hover: assert property (@(posedge clk) disable iff (!arst_n)
		shown_ok_q |-> (hover_ok_q && shown_idx_q == hover_idx_q))
		else $error("shown region differs from hovered region");

endmodule
